// ===== design/pstsch_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pstsch_pkg: shared types and constants of the priority task scheduler
// Slot table geometry, state and action codes, handshake payloads and the
// priority and slice helpers used by the sequencer.
// ----------------------------------------------------------------------------
package pstsch_pkg;

    localparam int TASK_SLOTS      = 16;
    localparam int PRIORITY_LEVELS = 16;

    localparam int IDX_W    = $clog2(TASK_SLOTS);
    localparam int PRI_W    = $clog2(PRIORITY_LEVELS);
    localparam int ACT_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int ST_W     = 3;
    localparam int PRI_IN_W = 4;
    localparam int SL_W     = 6;

    localparam int SLICE_MAX   = 63;
    localparam int SLICE_RESET = 2;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [PRI_W-1:0] t_pri;
    typedef logic [SL_W-1:0]  t_sl;

    typedef enum logic [ST_W-1:0] {
        TS_EMPTY   = 3'd0,
        TS_READY   = 3'd1,
        TS_RUNNING = 3'd2,
        TS_STOPPED = 3'd3,
        TS_ZOMBIE  = 3'd4
    } t_task_st;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_PRIO  = 2'd2,
        ACT_STATE = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_REAP,
        S_DECIDE,
        S_SCAN,
        S_REFILL,
        S_FIX_CUR,
        S_FIX_PICK,
        S_DONE
    } t_seq_st;

    typedef struct packed {
        t_task_st state;
        t_pri     pri;
        t_sl      len;
        t_sl      left;
    } t_entry;

    typedef struct packed {
        logic   st_we;
        logic   pri_we;
        logic   len_we;
        logic   left_we;
        t_idx   addr;
        t_entry data;
    } t_wr;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [SLOT_W-1:0]   slot;
        logic [ST_W-1:0]     new_state;
        logic [PRI_IN_W-1:0] new_priority;
        logic [SL_W-1:0]     new_slice;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] current_slot;
        logic              current_valid;
        logic              switched;
    } t_res;

    function automatic t_pri clamp_prio(input logic [PRI_IN_W-1:0] p);
        if (32'(p) > PRIORITY_LEVELS - 1) begin
            return t_pri'(PRIORITY_LEVELS - 1);
        end
        return t_pri'(p);
    endfunction

    function automatic t_sl slice_of_prio(input t_pri p);
        logic [PRI_W+1:0] s;
        s = {1'b0, p, 1'b0};
        if (p == '0) begin
            return t_sl'(SLICE_RESET);
        end
        if (32'(s) > SLICE_MAX) begin
            return t_sl'(SLICE_MAX);
        end
        return t_sl'(s);
    endfunction

    function automatic t_idx next_idx(input t_idx i);
        if (i == t_idx'(TASK_SLOTS - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== design/pstsch_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pstsch_in_if: request channel of the task scheduler
// Valid/ready channel carrying one action item.
// ----------------------------------------------------------------------------
interface pstsch_in_if;
    logic                               valid;
    logic                               ready;
    logic [pstsch_pkg::ACT_W-1:0]       action;
    logic [pstsch_pkg::SLOT_W-1:0]      slot;
    logic [pstsch_pkg::ST_W-1:0]        new_state;
    logic [pstsch_pkg::PRI_IN_W-1:0]    new_priority;
    logic [pstsch_pkg::SL_W-1:0]        new_slice;

    modport source (
        output valid, action, slot, new_state, new_priority, new_slice,
        input  ready
    );
    modport sink (
        input  valid, action, slot, new_state, new_priority, new_slice,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/pstsch_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pstsch_out_if: result channel of the task scheduler
// Valid/ready channel carrying the current slot and switch flag.
// ----------------------------------------------------------------------------
interface pstsch_out_if;
    logic                          valid;
    logic                          ready;
    logic [pstsch_pkg::SLOT_W-1:0] current_slot;
    logic                          current_valid;
    logic                          switched;

    modport source (
        output valid, current_slot, current_valid, switched,
        input  ready
    );
    modport sink (
        input  valid, current_slot, current_valid, switched,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/pstsch_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pstsch_table: task slot table
// One read address and one write address a cycle; per-field write enables.
// ----------------------------------------------------------------------------
module pstsch_table (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pstsch_pkg::t_idx    i_rd_addr,
    output pstsch_pkg::t_entry       o_rd,
    input  wire pstsch_pkg::t_wr     i_wr
);
    import pstsch_pkg::*;

    t_entry r_tab [TASK_SLOTS];

    assign o_rd = r_tab[i_rd_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_tab[i].state <= TS_EMPTY;
                r_tab[i].pri   <= '0;
                r_tab[i].len   <= t_sl'(SLICE_RESET);
                r_tab[i].left  <= '0;
            end
        end else begin
            if (i_wr.st_we) begin
                r_tab[i_wr.addr].state <= i_wr.data.state;
            end
            if (i_wr.pri_we) begin
                r_tab[i_wr.addr].pri <= i_wr.data.pri;
            end
            if (i_wr.len_we) begin
                r_tab[i_wr.addr].len <= i_wr.data.len;
            end
            if (i_wr.left_we) begin
                r_tab[i_wr.addr].left <= i_wr.data.left;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/pstsch_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pstsch_seq: scheduling sequencer
// Steps one slot a cycle through init, reap, scan and refill passes, sharing a
// single compare unit over the table read port.
// ----------------------------------------------------------------------------
module pstsch_seq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire pstsch_pkg::t_item   i_item,
    output pstsch_pkg::t_idx         o_rd_addr,
    input  wire pstsch_pkg::t_entry  i_rd,
    output pstsch_pkg::t_wr          o_wr,
    output logic                     o_done,
    output pstsch_pkg::t_res         o_res,
    input  wire logic                i_out_free
);
    import pstsch_pkg::*;

    t_seq_st r_state, n_state;
    t_idx    r_idx, n_idx;
    t_idx    r_cnt, n_cnt;
    t_idx    r_cur, n_cur;
    logic    r_cur_ok, n_cur_ok;
    t_pri    r_best, n_best;
    logic    r_best_ok, n_best_ok;
    logic    r_cur_run, n_cur_run;
    t_pri    r_cur_pri, n_cur_pri;
    logic    r_cur_lnz, n_cur_lnz;
    t_idx    r_pick, n_pick;
    logic    r_pick_ok, n_pick_ok;
    logic    r_pick_nz, n_pick_nz;
    logic    r_sw, n_sw;

    logic    acc, in_rng, st_ok, at_cur, last, scan_last;
    logic    is_ready, is_run, match_best, better, keep, switching, scan_end;
    t_action act;
    t_pri    in_pri;
    t_idx    in_addr;

    assign acc        = i_in_valid && o_in_ready;
    assign act        = t_action'(i_item.action);
    assign in_rng     = 32'(i_item.slot) < TASK_SLOTS;
    assign st_ok      = i_item.new_state <= ST_W'(TS_ZOMBIE);
    assign in_pri     = clamp_prio(i_item.new_priority);
    assign in_addr    = t_idx'(i_item.slot);
    assign at_cur     = r_idx == r_cur;
    assign last       = r_idx == t_idx'(TASK_SLOTS - 1);
    assign scan_last  = r_cnt == t_idx'(TASK_SLOTS - 1);
    assign is_ready   = i_rd.state == TS_READY;
    assign is_run     = i_rd.state == TS_RUNNING;
    assign match_best = r_best_ok && (i_rd.pri == r_best);
    assign better     = !r_best_ok || (i_rd.pri > r_best);
    assign keep       = r_cur_run && r_cur_lnz && (r_cur_pri >= r_best);
    assign switching  = r_pick_ok && (r_pick != r_cur);
    assign scan_end   = (is_ready && match_best && (i_rd.left != '0)) || scan_last;

    assign o_res = '{current_slot: SLOT_W'(r_cur), current_valid: r_cur_ok, switched: r_sw};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (act == ACT_TICK) begin
                        n_state = r_cur_ok ? S_REAP : S_INIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_INIT: begin
                if (is_ready || last) begin
                    n_state = S_DONE;
                end
            end
            S_REAP: begin
                if (last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = keep ? S_DONE : S_SCAN;
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = (n_pick_ok && !n_pick_nz) ? S_REFILL : S_FIX_CUR;
                end
            end
            S_REFILL: begin
                if (last) begin
                    n_state = S_FIX_CUR;
                end
            end
            S_FIX_CUR: begin
                n_state = switching ? S_FIX_PICK : S_DONE;
            end
            S_FIX_PICK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        o_in_ready = 1'b0;
        o_done     = 1'b0;
        o_rd_addr  = r_idx;
        o_wr       = '0;
        o_wr.addr  = r_idx;
        o_wr.data  = i_rd;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_cur_ok   = r_cur_ok;
        n_best     = r_best;
        n_best_ok  = r_best_ok;
        n_cur_run  = r_cur_run;
        n_cur_pri  = r_cur_pri;
        n_cur_lnz  = r_cur_lnz;
        n_pick     = r_pick;
        n_pick_ok  = r_pick_ok;
        n_pick_nz  = r_pick_nz;
        n_sw       = r_sw;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (acc) begin
                    n_sw      = 1'b0;
                    n_idx     = '0;
                    n_best_ok = 1'b0;
                    n_pick_ok = 1'b0;
                    n_pick_nz = 1'b0;
                    o_wr.addr = in_addr;
                    o_wr.data.state = t_task_st'(i_item.new_state);
                    o_wr.data.pri   = in_pri;
                    if (act == ACT_LOAD && in_rng) begin
                        o_wr.st_we   = st_ok;
                        o_wr.pri_we  = 1'b1;
                        o_wr.len_we  = 1'b1;
                        o_wr.left_we = 1'b1;
                        o_wr.data.len  = (i_item.new_slice == '0) ? t_sl'(1) : i_item.new_slice;
                        o_wr.data.left = o_wr.data.len;
                    end else if (act == ACT_PRIO && in_rng) begin
                        o_wr.pri_we  = 1'b1;
                        o_wr.len_we  = 1'b1;
                        o_wr.left_we = 1'b1;
                        o_wr.data.len  = slice_of_prio(in_pri);
                        o_wr.data.left = o_wr.data.len;
                    end else if (act == ACT_STATE && in_rng) begin
                        o_wr.st_we = st_ok;
                    end
                end
            end
            S_INIT: begin
                n_idx = next_idx(r_idx);
                if (is_ready) begin
                    o_wr.st_we      = 1'b1;
                    o_wr.data.state = TS_RUNNING;
                    n_cur           = r_idx;
                    n_cur_ok        = 1'b1;
                    n_sw            = 1'b1;
                end
            end
            S_REAP: begin
                n_idx = next_idx(r_idx);
                if (!at_cur && i_rd.state == TS_ZOMBIE) begin
                    o_wr.st_we      = 1'b1;
                    o_wr.data.state = TS_EMPTY;
                end
                if (at_cur) begin
                    n_cur_run = is_run;
                    n_cur_pri = i_rd.pri;
                    n_cur_lnz = i_rd.left > t_sl'(1);
                    if (i_rd.left != '0) begin
                        o_wr.left_we   = 1'b1;
                        o_wr.data.left = i_rd.left - 1'b1;
                    end
                end
                if ((is_ready || (at_cur && is_run)) && better) begin
                    n_best    = i_rd.pri;
                    n_best_ok = 1'b1;
                end
            end
            S_DECIDE: begin
                n_idx = next_idx(r_cur);
                n_cnt = '0;
            end
            S_SCAN: begin
                n_idx = next_idx(r_idx);
                n_cnt = r_cnt + 1'b1;
                if (is_ready && match_best) begin
                    if (i_rd.left != '0) begin
                        n_pick    = r_idx;
                        n_pick_ok = 1'b1;
                        n_pick_nz = 1'b1;
                    end else if (!r_pick_ok) begin
                        n_pick    = r_idx;
                        n_pick_ok = 1'b1;
                    end
                end
                if (scan_end) begin
                    n_idx = (n_pick_ok && !n_pick_nz) ? t_idx'(0) : r_cur;
                end
            end
            S_REFILL: begin
                n_idx = last ? r_cur : next_idx(r_idx);
                if ((is_ready || (at_cur && is_run)) && match_best) begin
                    o_wr.left_we   = 1'b1;
                    o_wr.data.left = i_rd.len;
                end
            end
            S_FIX_CUR: begin
                n_idx = r_pick;
                n_sw  = switching;
                if (switching) begin
                    if (is_run) begin
                        o_wr.st_we      = 1'b1;
                        o_wr.data.state = TS_READY;
                    end
                end else if (i_rd.left == '0) begin
                    o_wr.left_we   = 1'b1;
                    o_wr.data.left = i_rd.len;
                end
            end
            S_FIX_PICK: begin
                o_wr.st_we      = 1'b1;
                o_wr.data.state = TS_RUNNING;
                n_cur           = r_idx;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_cur     <= '0;
            r_cur_ok  <= 1'b0;
            r_best    <= '0;
            r_best_ok <= 1'b0;
            r_cur_run <= 1'b0;
            r_cur_pri <= '0;
            r_cur_lnz <= 1'b0;
            r_pick    <= '0;
            r_pick_ok <= 1'b0;
            r_pick_nz <= 1'b0;
            r_sw      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_cur_ok  <= n_cur_ok;
            r_best    <= n_best;
            r_best_ok <= n_best_ok;
            r_cur_run <= n_cur_run;
            r_cur_pri <= n_cur_pri;
            r_cur_lnz <= n_cur_lnz;
            r_pick    <= n_pick;
            r_pick_ok <= n_pick_ok;
            r_pick_nz <= n_pick_nz;
            r_sw      <= n_sw;
        end
    end

endmodule
`default_nettype wire

// ===== design/priority_slice_task_scheduler_top.sv =====
`default_nettype none
// Load, priority and state items go from idle straight to the done state;
// a tick with no current task makes an init pass up to the first ready
// slot. A tick with a current task makes reap, scan and refill passes,
// which step one slot a cycle over the single table read port. One item
// at a time; ready is high only when idle. Reset clears the whole slot
// table and the current task.
// ----------------------------------------------------------------------------
// priority_slice_task_scheduler_top: priority time-slice task scheduler
// Slot table, scheduling sequencer and a registered result stage.
// ----------------------------------------------------------------------------
module priority_slice_task_scheduler_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pstsch_in_if.sink    i_item,
    pstsch_out_if.source o_res
);
    import pstsch_pkg::*;

    t_item  item;
    t_idx   rd_addr;
    t_entry rd;
    t_wr    wr;
    t_res   seq_res;
    logic   seq_done;
    logic   out_free;

    logic   r_ovalid, n_ovalid;
    t_res   r_res, n_res;

    assign item = '{action: i_item.action, slot: i_item.slot,
                    new_state: i_item.new_state, new_priority: i_item.new_priority,
                    new_slice: i_item.new_slice};

    pstsch_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr      (wr)
    );

    pstsch_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_item     (item),
        .o_rd_addr  (rd_addr),
        .i_rd       (rd),
        .o_wr       (wr),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .i_out_free (out_free)
    );

    assign out_free = !r_ovalid || o_res.ready;

    always_comb begin
        n_ovalid = r_ovalid;
        n_res    = r_res;
        if (seq_done && out_free) begin
            n_ovalid = 1'b1;
            n_res    = seq_res;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
        end
        r_res <= n_res;
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.current_slot  = r_res.current_slot;
    assign o_res.current_valid = r_res.current_valid;
    assign o_res.switched      = r_res.switched;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("scheduler took a second item while busy");

    a_switch_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.switched || o_res.current_valid))
        else $error("switch reported without a current task");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready && !seq_done |=> !o_res.valid)
        else $error("result stage kept an item after it was taken");

endmodule
`default_nettype wire

// ===== verif/priority_slice_task_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_slice_task_scheduler_top_tb: testbench of the priority scheduler
// Drives load, priority, state and tick items, tracks the slot table in a
// behavioural copy and checks every reported slot, valid flag and switch
// flag in order, under random idling and long result back-pressure.
// ----------------------------------------------------------------------------
module priority_slice_task_scheduler_top_tb;
    import pstsch_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pstsch_in_if  req_if ();
    pstsch_out_if res_if ();

    priority_slice_task_scheduler_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [ST_W-1:0] tbl_state [TASK_SLOTS];
    t_pri            tbl_pri   [TASK_SLOTS];
    t_sl             tbl_len   [TASK_SLOTS];
    t_sl             tbl_left  [TASK_SLOTS];
    t_idx            cur_slot;
    logic            cur_valid;

    t_res        slot_report_q [$];
    int unsigned mismatch_cnt = 0;
    int unsigned hold_len     = 0;
    int unsigned hold_ask     = 0;
    int unsigned hold_seen    = 0;
    int unsigned sink_gap     = 0;
    logic        idling_on    = 1'b1;

    function automatic logic sched_tick();
        int   n;
        int   k;
        int   best;
        int   pick;
        t_idx cur;
        best = -1;
        pick = -1;
        if (!cur_valid) begin
            for (n = 0; n < TASK_SLOTS; n++) begin
                if (tbl_state[n] == TS_READY) begin
                    tbl_state[n] = TS_RUNNING;
                    cur_slot = t_idx'(n);
                    cur_valid = 1'b1;
                    return 1'b1;
                end
            end
            return 1'b0;
        end
        cur = cur_slot;
        for (n = 0; n < TASK_SLOTS; n++) begin
            if (n != int'(cur) && tbl_state[n] == TS_ZOMBIE) begin
                tbl_state[n] = TS_EMPTY;
            end
        end
        if (tbl_left[cur] != '0) begin
            tbl_left[cur] = tbl_left[cur] - 1'b1;
        end
        for (n = 0; n < TASK_SLOTS; n++) begin
            if (tbl_state[n] == TS_READY && int'(tbl_pri[n]) > best) begin
                best = int'(tbl_pri[n]);
            end
        end
        if (tbl_state[cur] == TS_RUNNING && int'(tbl_pri[cur]) > best) begin
            best = int'(tbl_pri[cur]);
        end
        if (tbl_state[cur] == TS_RUNNING && tbl_left[cur] != '0 &&
            int'(tbl_pri[cur]) >= best) begin
            return 1'b0;
        end
        // ring order from the slot after the current one
        for (k = 1; k <= TASK_SLOTS; k++) begin
            n = (int'(cur) + k) % TASK_SLOTS;
            if (tbl_state[n] == TS_READY && int'(tbl_pri[n]) == best) begin
                if (tbl_left[n] != '0) begin
                    pick = n;
                    break;
                end
                if (pick < 0) begin
                    pick = n;
                end
            end
        end
        if (pick >= 0 && tbl_left[pick] == '0) begin
            for (n = 0; n < TASK_SLOTS; n++) begin
                if (tbl_state[n] == TS_READY && int'(tbl_pri[n]) == best) begin
                    tbl_left[n] = tbl_len[n];
                end
            end
            if (tbl_state[cur] == TS_RUNNING && int'(tbl_pri[cur]) == best) begin
                tbl_left[cur] = tbl_len[cur];
            end
        end
        if (pick >= 0 && pick != int'(cur)) begin
            if (tbl_state[cur] == TS_RUNNING) begin
                tbl_state[cur] = TS_READY;
            end
            tbl_state[pick] = TS_RUNNING;
            cur_slot = t_idx'(pick);
            return 1'b1;
        end
        if (tbl_left[cur] == '0) begin
            tbl_left[cur] = tbl_len[cur];
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_step(input t_item it);
        t_res r;
        logic sw;
        t_pri p;
        int   s;
        t_idx a;
        sw = 1'b0;
        a = t_idx'(it.slot);
        p = (int'(it.new_priority) > PRIORITY_LEVELS - 1) ?
            t_pri'(PRIORITY_LEVELS - 1) : t_pri'(it.new_priority);
        if (t_action'(it.action) == ACT_TICK) begin
            sw = sched_tick();
        end else if (int'(it.slot) < TASK_SLOTS) begin
            case (t_action'(it.action))
                ACT_LOAD: begin
                    if (it.new_state <= TS_ZOMBIE) begin
                        tbl_state[a] = it.new_state;
                    end
                    tbl_pri[a]  = p;
                    tbl_len[a]  = (it.new_slice == '0) ? t_sl'(1) : it.new_slice;
                    tbl_left[a] = tbl_len[a];
                end
                ACT_PRIO: begin
                    s = (p == '0) ? 2 : 2 * int'(p);
                    if (s > SLICE_MAX) begin
                        s = SLICE_MAX;
                    end
                    tbl_pri[a]  = p;
                    tbl_len[a]  = t_sl'(s);
                    tbl_left[a] = t_sl'(s);
                end
                default: begin
                    if (it.new_state <= TS_ZOMBIE) begin
                        tbl_state[a] = it.new_state;
                    end
                end
            endcase
        end
        r.current_slot  = SLOT_W'(cur_slot);
        r.current_valid = cur_valid;
        r.switched      = sw;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // result side: random stalls plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_len <= 300;
            res_if.ready <= 1'b0;
        end else if (hold_len != 0) begin
            hold_len <= hold_len - 1;
            res_if.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap <= sink_gap - 1;
            res_if.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            sink_gap <= $urandom_range(0, 4);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (slot_report_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot %0d",
                                          res_if.current_slot));
            end else begin
                want = slot_report_q.pop_front();
                if (res_if.current_slot !== want.current_slot) begin
                    report_mismatch($sformatf("current_slot %0d, want %0d",
                                              res_if.current_slot, want.current_slot));
                end
                if (res_if.current_valid !== want.current_valid) begin
                    report_mismatch($sformatf("current_valid %0b, want %0b",
                                              res_if.current_valid, want.current_valid));
                end
                if (res_if.switched !== want.switched) begin
                    report_mismatch($sformatf("switched %0b, want %0b",
                                              res_if.switched, want.switched));
                end
            end
        end
    end

    task automatic send_item(input t_item it);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.action       <= it.action;
        req_if.slot         <= it.slot;
        req_if.new_state    <= it.new_state;
        req_if.new_priority <= it.new_priority;
        req_if.new_slice    <= it.new_slice;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        slot_report_q.push_back(predict_step(it));
    endtask

    task automatic issue(input t_action act, input int slot, input int st,
                         input int pri, input int sl);
        t_item it;
        it.action       = act;
        it.slot         = SLOT_W'(slot);
        it.new_state    = ST_W'(st);
        it.new_priority = PRI_IN_W'(pri);
        it.new_slice    = SL_W'(sl);
        send_item(it);
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (slot_report_q.size() != 0);
    endtask

    function automatic int pick_slice();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4);
    endfunction

    function automatic int pick_state();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return int'(TS_READY);
        if (r < 55) return int'(TS_STOPPED);
        if (r < 70) return int'(TS_ZOMBIE);
        if (r < 85) return int'(TS_EMPTY);
        if (r < 90) return int'(TS_RUNNING);
        return $urandom_range(5, 7);
    endfunction

    task automatic test_idle_table();
        issue(ACT_TICK, 0, 0, 0, 0);
        issue(ACT_STATE, 0, 5, 0, 0);
        issue(ACT_TICK, 15, 7, 15, 63);
    endtask

    task automatic test_load_fields();
        issue(ACT_LOAD, 0, 7, 15, 0);
        issue(ACT_LOAD, 15, TS_READY, 15, 63);
        issue(ACT_LOAD, 5, 6, 0, 5);
        issue(ACT_PRIO, 5, 0, 1, 0);
        issue(ACT_PRIO, 0, 0, 0, 0);
        issue(ACT_STATE, 3, TS_READY, 0, 0);
        issue(ACT_PRIO, 3, 0, 0, 0);
    endtask

    task automatic test_first_pick();
        issue(ACT_TICK, 0, 0, 0, 0);
        issue(ACT_TICK, 0, 0, 0, 0);
    endtask

    task automatic test_current_edits();
        issue(ACT_LOAD, 7, TS_READY, 15, 1);
        issue(ACT_STATE, 15, TS_ZOMBIE, 0, 0);
        issue(ACT_TICK, 0, 0, 0, 0);
        issue(ACT_TICK, 0, 0, 0, 0);
        issue(ACT_STATE, 7, TS_STOPPED, 0, 0);
        issue(ACT_STATE, 3, TS_STOPPED, 0, 0);
        issue(ACT_TICK, 0, 0, 0, 0);
    endtask

    task automatic test_round_robin();
        issue(ACT_STATE, 3, TS_READY, 0, 0);
        issue(ACT_LOAD, 9, TS_READY, 0, 2);
        issue(ACT_LOAD, 12, TS_READY, 0, 1);
        repeat (5) issue(ACT_TICK, 0, 0, 0, 0);
    endtask

    task automatic test_backpressure();
        int n;
        hold_ask <= hold_ask + 1;
        for (n = 0; n < 10; n++) begin
            if (n % 3 == 0) begin
                issue(ACT_LOAD, $urandom_range(0, 15), TS_READY, $urandom_range(0, 2),
                      pick_slice());
            end else begin
                issue(ACT_TICK, 0, 0, 0, 0);
            end
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input logic allow_idle);
        int unsigned sent;
        int unsigned r;
        int          base;
        int          span;
        t_item       it;
        sent = 0;
        while (sent < n_items) begin
            idling_on <= allow_idle && ($urandom_range(0, 9) < 7);
            base = $urandom_range(0, 15);
            span = $urandom_range(0, 2);
            repeat ($urandom_range(2, 6)) begin
                issue(ACT_LOAD, $urandom_range(0, 15),
                      ($urandom_range(0, 5) == 0) ? pick_state() : int'(TS_READY),
                      (base + $urandom_range(0, span)) % 16, pick_slice());
                sent++;
            end
            repeat ($urandom_range(10, 30)) begin
                r = $urandom_range(0, 99);
                if (r < 62) begin
                    issue(ACT_TICK, $urandom_range(0, 15), $urandom_range(0, 7),
                          $urandom_range(0, 15), $urandom_range(0, 63));
                end else if (r < 74) begin
                    issue(ACT_STATE, $urandom_range(0, 15), pick_state(),
                          $urandom_range(0, 15), $urandom_range(0, 63));
                end else if (r < 84) begin
                    issue(ACT_PRIO, $urandom_range(0, 15), $urandom_range(0, 7),
                          (base + $urandom_range(0, span)) % 16, $urandom_range(0, 63));
                end else if (r < 92) begin
                    issue(ACT_LOAD, $urandom_range(0, 15), pick_state(),
                          (base + $urandom_range(0, span)) % 16, pick_slice());
                end else begin
                    it.action       = t_action'($urandom_range(0, 3));
                    it.slot         = SLOT_W'($urandom_range(0, 15));
                    it.new_state    = ST_W'($urandom_range(0, 7));
                    it.new_priority = PRI_IN_W'($urandom_range(0, 15));
                    it.new_slice    = SL_W'($urandom_range(0, 63));
                    send_item(it);
                end
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin : main_seq
        int n;
        for (n = 0; n < TASK_SLOTS; n++) begin
            tbl_state[n] = TS_EMPTY;
            tbl_pri[n]   = '0;
            tbl_len[n]   = t_sl'(SLICE_RESET);
            tbl_left[n]  = '0;
        end
        cur_slot  = '0;
        cur_valid = 1'b0;
        req_if.valid        <= 1'b0;
        req_if.action       <= ACT_TICK;
        req_if.slot         <= '0;
        req_if.new_state    <= '0;
        req_if.new_priority <= '0;
        req_if.new_slice    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_table();
        test_load_fields();
        test_first_pick();
        test_current_edits();
        test_round_robin();
        wait_for_results();
        test_backpressure();
        test_random_traffic(830, 1'b1);
        wait_for_results();
        test_random_traffic(60, 1'b0);

        wait_for_results();
        repeat (64) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASS priority_slice_task_scheduler_top");
        end else begin
            $display("FAIL priority_slice_task_scheduler_top");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL priority_slice_task_scheduler_top");
        $finish;
    end

endmodule
